/* rtl/core/prr_pkg.sv */
// prr_pkg: shared constants, field widths and the controller/datapath
// command and status structs for the perceptron reuse replacement block.
// No dependencies.
`timescale 1ns / 1ps

package prr_pkg;

  // default geometry
  localparam int NUM_SETS_DEF     = 4096;
  localparam int WAYS_DEF         = 16;
  localparam int SAMPLER_SETS_DEF = 64;

  // fixed predictor shape
  localparam int TABLE_ENTRIES = 256;
  localparam int FEATURES      = 6;
  localparam int HASH_W        = 8;
  localparam int WEIGHT_W      = 6;
  localparam int SUM_W         = 9;

  localparam logic signed [WEIGHT_W-1:0] W_MAX = 6'sd31;
  localparam logic signed [WEIGHT_W-1:0] W_MIN = -6'sd32;

  // reciprocal scaling for divide-by-constant
  localparam int RECIP_K = 16;

  // configuration register indexes and reset values
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAIN_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REUSE_THR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAG_SHIFT  = 2'd3;

  localparam logic [7:0]        TRAIN_THR_RST  = 8'd68;
  localparam logic signed [8:0] BYPASS_THR_RST = 9'sd3;
  localparam logic signed [8:0] REUSE_THR_RST  = 9'sd124;
  localparam logic [5:0]        TAG_SHIFT_RST  = 6'd18;

  typedef struct packed {
    logic is_update;
    logic samp;
    logic hit;
    logic way_ok;
    logic clr_done;
  } prr_status_t;

  typedef struct packed {
    logic clr;
    logic take;
    logic dec_a;
    logic dec_b;
    logic dec_c;
    logic dec_d;
    logic q_find;
    logic chk_up;
    logic chk_dn;
    logic hash;
    logic hist_shift;
    logic set_entry;
    logic wsel_t;
    logic w_inc;
    logic w_dec;
    logic q_decide;
    logic f_write;
    logic lru_wr;
    logic plru_wr;
    logic reuse_wr;
    logic out_ld;
  } prr_cmd_t;

endpackage

/* rtl/core/prr_datapath.sv */
// prr_datapath: input latch, set decode, weight tables, sampler and
// replacement state memories, and the result register.
// Depends on prr_pkg; driven by prr_ctrl through prr_cmd_t.
`timescale 1ns / 1ps

module prr_datapath #(
  parameter int NUM_SETS     = prr_pkg::NUM_SETS_DEF,
  parameter int WAYS         = prr_pkg::WAYS_DEF,
  parameter int SAMPLER_SETS = prr_pkg::SAMPLER_SETS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  prr_pkg::prr_cmd_t             cmd,
  output prr_pkg::prr_status_t          status,
  input  logic                          cfg_write,
  input  logic [prr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          opcode,
  input  logic [11:0]                   set_index,
  input  logic [3:0]                    way,
  input  logic [10:0]                   pc,
  input  logic [63:0]                   address,
  input  logic [14:0]                   line_tag,
  input  logic                          is_hit,
  output logic [3:0]                    victim_way,
  output logic                          bypass
);
  import prr_pkg::*;

  localparam int SETW     = $clog2(NUM_SETS);
  localparam int WW       = $clog2(WAYS);
  localparam int SW       = (SAMPLER_SETS > 1) ? $clog2(SAMPLER_SETS) : 1;
  localparam int ENTRIES  = SAMPLER_SETS * WAYS;
  localparam int EW       = $clog2(ENTRIES);
  localparam int INTERVAL = ((NUM_SETS / SAMPLER_SETS) > 0) ? (NUM_SETS / SAMPLER_SETS) : 1;
  localparam int MN       = (1 << RECIP_K) / NUM_SETS;
  localparam int MI       = (1 << RECIP_K) / INTERVAL;
  localparam int CLR_A    = (NUM_SETS > ENTRIES) ? NUM_SETS : ENTRIES;
  localparam int CLR_DEPTH = (CLR_A > TABLE_ENTRIES) ? CLR_A : TABLE_ENTRIES;
  localparam int CLR_W    = $clog2(CLR_DEPTH);

  typedef logic [WAYS-1:0][WW-1:0]     lru_row_t;
  typedef logic [FEATURES-1:0][HASH_W-1:0] idx_row_t;

  // latched item
  logic        op_r, hit_r;
  logic [11:0] set_r;
  logic [3:0]  way_r;
  logic [10:0] pc_r;
  logic [63:0] addr_r;
  logic [14:0] ltag_r;

  // configuration
  logic [7:0]        train_thr;
  logic signed [8:0] bypass_thr;
  logic signed [8:0] reuse_thr;
  logic [5:0]        tag_shift;

  // decode and working registers
  logic [28:0]      prod_n;
  logic [33:0]      prod_i;
  logic [SETW-1:0]  setm;
  logic [SW-1:0]    s_r;
  logic             samp_r;
  logic [14:0]      tag_r;
  logic [10:0]      hist [3];
  logic [WW-1:0]    v_r;
  logic [EW-1:0]    e_r;
  idx_row_t         fidx, tidx;
  logic             tflag;
  logic [3:0]       victim_r;
  logic             byp_r;
  logic [CLR_W-1:0] clr_cnt;

  // memory read data
  logic [WAYS-1:0]  reuse_q;
  logic [WAYS-2:0]  plru_q;
  lru_row_t         lru_q;
  idx_row_t         feat_q;
  logic [SUM_W-1:0] sum_q;
  logic [FEATURES-1:0][WEIGHT_W-1:0] w_q;

  // memories
  logic [WAYS-1:0]  reuse_mem [NUM_SETS];
  logic [WAYS-2:0]  plru_mem  [NUM_SETS];
  lru_row_t         lru_mem   [SAMPLER_SETS];
  idx_row_t         feat_mem  [ENTRIES];
  logic [SUM_W-1:0] sum_mem   [ENTRIES];

  // combinational helpers
  logic [WW-1:0]      way_i;
  idx_row_t           hash_c;
  logic signed [8:0]  wsum_c;
  logic [WW-1:0]      lru_found;
  logic [WW-1:0]      clear_found;
  logic               any_clear;
  logic [3:0]         plru_vic;
  logic [WAYS-2:0]    plru_new;
  logic [WAYS-1:0]    reuse_new;
  lru_row_t           lru_new;
  logic [FEATURES-1:0][WEIGHT_W-1:0] w_new;
  logic [31:0]        rn_c, qi_c, ri_c;
  logic               byp_take;
  logic signed [9:0]  sum_q_x, theta_x;

  function automatic lru_row_t lru_init();
    lru_row_t r;
    for (int w = 0; w < WAYS; w++) r[w] = WW'(w);
    return r;
  endfunction

  assign way_i = WW'(way_r);

  // feature hashes; same form for a query and for a fill ahead of the history shift
  always_comb begin
    logic [7:0] p;
    p = pc_r[7:0];
    hash_c[0] = pc_r[9:2] ^ p;
    hash_c[1] = hist[0][8:1] ^ p;
    hash_c[2] = hist[1][9:2] ^ p;
    hash_c[3] = hist[2][10:3] ^ p;
    hash_c[4] = tag_r[11:4] ^ p;
    hash_c[5] = tag_r[14:7] ^ p;
  end

  always_comb begin
    wsum_c = '0;
    for (int f = 0; f < FEATURES; f++)
      wsum_c = wsum_c + $signed({{(SUM_W-WEIGHT_W){w_q[f][WEIGHT_W-1]}}, w_q[f]});
  end

  assign byp_take = wsum_c > bypass_thr;
  assign sum_q_x  = $signed({sum_q[SUM_W-1], sum_q});
  assign theta_x  = $signed({2'b00, train_thr});

  // sampler lru way and first way without a reuse prediction
  always_comb begin
    lru_found   = '0;
    clear_found = '0;
    any_clear   = 1'b0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (lru_q[w] == WW'(WAYS - 1)) lru_found = WW'(w);
      if (!reuse_q[w]) begin
        clear_found = WW'(w);
        any_clear   = 1'b1;
      end
    end
  end

  always_comb begin
    logic [WW:0] node;
    logic        b;
    node = '0;
    for (int k = 0; k <= WW; k++) begin
      if (node < (WW+1)'(WAYS - 1)) begin
        b = 1'b0;
        for (int n = 0; n < WAYS - 1; n++) if (node == (WW+1)'(n)) b = plru_q[n];
        node = (WW+1)'(2 * node + 1 + b);
      end
    end
    plru_vic = 4'(node - (WW+1)'(WAYS - 1));
  end

  always_comb begin
    logic [WW:0] idx;
    plru_new = plru_q;
    idx = (WW+1)'(WAYS - 1) + (WW+1)'(way_i);
    for (int k = 0; k <= WW; k++) begin
      if (idx != '0) begin
        if (!idx[0]) begin
          idx = (idx - (WW+1)'(2)) >> 1;
          for (int n = 0; n < WAYS - 1; n++) if (idx == (WW+1)'(n)) plru_new[n] = 1'b0;
        end else begin
          idx = (idx - (WW+1)'(1)) >> 1;
          for (int n = 0; n < WAYS - 1; n++) if (idx == (WW+1)'(n)) plru_new[n] = 1'b1;
        end
      end
    end
  end

  // reuse row with the accessed way's prediction replaced
  always_comb begin
    reuse_new        = reuse_q;
    reuse_new[way_i] = wsum_c < reuse_thr;
  end

  always_comb begin
    logic [WW-1:0] cur;
    cur = lru_q[way_i];
    for (int w = 0; w < WAYS; w++)
      lru_new[w] = (lru_q[w] < cur) ? lru_q[w] + 1'b1 : lru_q[w];
    lru_new[way_i] = '0;
  end

  always_comb begin
    for (int f = 0; f < FEATURES; f++) begin
      if (cmd.w_inc)
        w_new[f] = ($signed(w_q[f]) == W_MAX) ? w_q[f] : w_q[f] + 1'b1;
      else
        w_new[f] = ($signed(w_q[f]) == W_MIN) ? w_q[f] : w_q[f] - 1'b1;
    end
  end

  // set modulo and sampler number by reciprocal multiply with one correction
  always_comb begin
    rn_c = 32'(set_r) - 32'(prod_n[28:RECIP_K]) * 32'(NUM_SETS);
    if (rn_c >= 32'(NUM_SETS)) rn_c = rn_c - 32'(NUM_SETS);
    qi_c = 32'(prod_i[33:RECIP_K]);
    ri_c = 32'(setm) - qi_c * 32'(INTERVAL);
    if (ri_c >= 32'(INTERVAL)) begin
      qi_c = qi_c + 32'd1;
      ri_c = ri_c - 32'(INTERVAL);
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      train_thr  <= TRAIN_THR_RST;
      bypass_thr <= BYPASS_THR_RST;
      reuse_thr  <= REUSE_THR_RST;
      tag_shift  <= TAG_SHIFT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_TRAIN_THR:  train_thr  <= cfg_data[7:0];
        CFG_BYPASS_THR: bypass_thr <= $signed(cfg_data);
        CFG_REUSE_THR:  reuse_thr  <= $signed(cfg_data);
        CFG_TAG_SHIFT:  tag_shift  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      hist[0] <= '0;
      hist[1] <= '0;
      hist[2] <= '0;
    end else begin
      if (cmd.clr) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.hist_shift || (cmd.q_decide && byp_take)) begin
        hist[2] <= hist[1];
        hist[1] <= hist[0];
        hist[0] <= pc_r;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r   <= opcode;
      set_r  <= set_index;
      way_r  <= way;
      pc_r   <= pc;
      addr_r <= address;
      ltag_r <= line_tag;
      hit_r  <= is_hit;
    end
    if (cmd.dec_a) begin
      prod_n <= 29'(set_r) * 29'(MN);
      tag_r  <= op_r ? ltag_r : 15'(addr_r >> tag_shift);
    end
    if (cmd.dec_b) setm <= SETW'(rn_c);
    if (cmd.dec_c) prod_i <= 34'(setm) * 34'(MI);
    if (cmd.dec_d) begin
      samp_r <= (ri_c == 32'd0) && (qi_c < 32'(SAMPLER_SETS));
      s_r    <= SW'(qi_c);
    end
    if (cmd.q_find) begin
      v_r      <= lru_found;
      e_r      <= EW'(32'(s_r) * 32'(WAYS) + 32'(lru_found));
      victim_r <= 4'(lru_found);
      byp_r    <= 1'b0;
    end
    if (cmd.set_entry) e_r <= EW'(32'(s_r) * 32'(WAYS) + 32'(way_i));
    if (cmd.hash) fidx <= hash_c;
    if (cmd.chk_up) begin
      tidx  <= feat_q;
      tflag <= (sum_q_x < theta_x) || reuse_q[v_r];
    end
    if (cmd.chk_dn) begin
      tidx  <= feat_q;
      tflag <= sum_q_x > (10'sd0 - theta_x);
    end
    if (cmd.q_decide) begin
      byp_r <= byp_take;
      if (byp_take)       victim_r <= '0;
      else if (any_clear) victim_r <= 4'(clear_found);
      else                victim_r <= plru_vic;
    end
    if (cmd.out_ld) begin
      victim_way <= victim_r;
      bypass     <= byp_r;
    end
  end

  // per-set rows
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      if ({1'b0, clr_cnt} < (CLR_W+1)'(NUM_SETS)) begin
        reuse_mem[clr_cnt[SETW-1:0]] <= '0;
        plru_mem[clr_cnt[SETW-1:0]]  <= '0;
      end
    end else begin
      if (cmd.reuse_wr) reuse_mem[setm] <= reuse_new;
      if (cmd.plru_wr) plru_mem[setm] <= plru_new;
    end
    reuse_q <= reuse_mem[setm];
    plru_q  <= plru_mem[setm];
  end

  // sampler rows and entries
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      if ({1'b0, clr_cnt} < (CLR_W+1)'(SAMPLER_SETS)) lru_mem[clr_cnt[SW-1:0]] <= lru_init();
      if ({1'b0, clr_cnt} < (CLR_W+1)'(ENTRIES)) begin
        feat_mem[clr_cnt[EW-1:0]] <= '0;
        sum_mem[clr_cnt[EW-1:0]]  <= '0;
      end
    end else begin
      if (cmd.lru_wr) lru_mem[s_r] <= lru_new;
      if (cmd.f_write) begin
        feat_mem[e_r] <= fidx;
        sum_mem[e_r]  <= wsum_c;
      end
    end
    lru_q  <= lru_mem[s_r];
    feat_q <= feat_mem[e_r];
    sum_q  <= sum_mem[e_r];
  end

  // weight tables, one memory each
  for (genvar f = 0; f < FEATURES; f++) begin : g_wt
    logic [WEIGHT_W-1:0] wt [TABLE_ENTRIES];
    logic [HASH_W-1:0]   widx;
    assign widx = cmd.wsel_t ? tidx[f] : fidx[f];
    always_ff @(posedge clk) begin
      if (cmd.clr) begin
        if ({1'b0, clr_cnt} < (CLR_W+1)'(TABLE_ENTRIES)) wt[clr_cnt[HASH_W-1:0]] <= '0;
      end else if ((cmd.w_inc || cmd.w_dec) && tflag) begin
        wt[tidx[f]] <= w_new[f];
      end
      w_q[f] <= wt[widx];
    end
  end

  always_comb begin
    status.is_update = op_r;
    status.samp      = samp_r;
    status.hit       = hit_r;
    status.way_ok    = 32'(way_r) < 32'(WAYS);
    status.clr_done  = clr_cnt == CLR_W'(CLR_DEPTH - 1);
  end

endmodule

/* rtl/core/prr_ctrl.sv */
// prr_ctrl: sequencer for the replacement block; walks each word through
// decode, query or update steps and owns the handshake state.
// Depends on prr_pkg; drives prr_datapath through prr_cmd_t.
`timescale 1ns / 1ps

module prr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  input  prr_pkg::prr_status_t status,
  output prr_pkg::prr_cmd_t    cmd
);
  import prr_pkg::*;

  typedef enum logic [26:0] {
    S_CLEAR    = 27'(1) << 0,
    S_IDLE     = 27'(1) << 1,
    S_DEC_A    = 27'(1) << 2,
    S_DEC_B    = 27'(1) << 3,
    S_DEC_C    = 27'(1) << 4,
    S_DEC_D    = 27'(1) << 5,
    S_DISP     = 27'(1) << 6,
    S_QS_FIND  = 27'(1) << 7,
    S_QS_RD    = 27'(1) << 8,
    S_QS_CHK   = 27'(1) << 9,
    S_QS_WRD   = 27'(1) << 10,
    S_QS_TRAIN = 27'(1) << 11,
    S_QH_HASH  = 27'(1) << 12,
    S_QH_WRD   = 27'(1) << 13,
    S_QH_CMP   = 27'(1) << 14,
    S_U_START  = 27'(1) << 15,
    S_UH_RD    = 27'(1) << 16,
    S_UH_CHK   = 27'(1) << 17,
    S_UH_WRD   = 27'(1) << 18,
    S_UH_TRAIN = 27'(1) << 19,
    S_UF_WRD   = 27'(1) << 20,
    S_UF_WRITE = 27'(1) << 21,
    S_UL_TOUCH = 27'(1) << 22,
    S_UP_TOUCH = 27'(1) << 23,
    S_UR_WRD   = 27'(1) << 24,
    S_UR_WRITE = 27'(1) << 25,
    S_OUT      = 27'(1) << 26
  } state_t;

  state_t state, state_next;

  assign req_stall = state != S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (status.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.take   = 1'b1;
          state_next = S_DEC_A;
        end
      end
      S_DEC_A: begin cmd.dec_a = 1'b1; state_next = S_DEC_B; end
      S_DEC_B: begin cmd.dec_b = 1'b1; state_next = S_DEC_C; end
      S_DEC_C: begin cmd.dec_c = 1'b1; state_next = S_DEC_D; end
      S_DEC_D: begin cmd.dec_d = 1'b1; state_next = S_DISP; end
      S_DISP: begin
        if (status.is_update)  state_next = S_U_START;
        else if (status.samp)  state_next = S_QS_FIND;
        else                   state_next = S_QH_HASH;
      end
      S_QS_FIND: begin cmd.q_find = 1'b1; state_next = S_QS_RD; end
      S_QS_RD:   state_next = S_QS_CHK;
      S_QS_CHK:  begin cmd.chk_up = 1'b1; state_next = S_QS_WRD; end
      S_QS_WRD:  begin cmd.wsel_t = 1'b1; state_next = S_QS_TRAIN; end
      S_QS_TRAIN: begin
        cmd.wsel_t = 1'b1;
        cmd.w_inc  = 1'b1;
        state_next = S_OUT;
      end
      S_QH_HASH: begin cmd.hash = 1'b1; state_next = S_QH_WRD; end
      S_QH_WRD:  state_next = S_QH_CMP;
      S_QH_CMP:  begin cmd.q_decide = 1'b1; state_next = S_OUT; end
      S_U_START: begin
        cmd.hash       = 1'b1;
        cmd.hist_shift = 1'b1;
        cmd.set_entry  = 1'b1;
        if (!status.way_ok)   state_next = S_IDLE;
        else if (!status.samp) state_next = S_UP_TOUCH;
        else if (status.hit)  state_next = S_UH_RD;
        else                  state_next = S_UF_WRD;
      end
      S_UH_RD:  state_next = S_UH_CHK;
      S_UH_CHK: begin cmd.chk_dn = 1'b1; state_next = S_UH_WRD; end
      S_UH_WRD: begin cmd.wsel_t = 1'b1; state_next = S_UH_TRAIN; end
      S_UH_TRAIN: begin
        cmd.wsel_t = 1'b1;
        cmd.w_dec  = 1'b1;
        state_next = S_UL_TOUCH;
      end
      S_UF_WRD:   state_next = S_UF_WRITE;
      S_UF_WRITE: begin cmd.f_write = 1'b1; state_next = S_UL_TOUCH; end
      S_UL_TOUCH: begin cmd.lru_wr = 1'b1; state_next = S_UR_WRD; end
      S_UP_TOUCH: begin cmd.plru_wr = 1'b1; state_next = S_UR_WRD; end
      S_UR_WRD:   state_next = S_UR_WRITE;
      S_UR_WRITE: begin cmd.reuse_wr = 1'b1; state_next = S_IDLE; end
      S_OUT: begin
        if (!(rsp_valid && rsp_stall)) begin
          cmd.out_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_ld)                    rsp_valid <= 1'b1;
      else if (rsp_valid && !rsp_stall)  rsp_valid <= 1'b0;
    end
  end

  a_rsp_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_OUT))
    else $error("result word raised outside the output step");

  a_take_decodes: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == S_DEC_A))
    else $error("accepted word did not enter decode");

  a_out_is_query: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> !status.is_update)
    else $error("update word reached the output step");

endmodule

/* rtl/core/perceptron_reuse_replacement_top.sv */
// perceptron_reuse_replacement_top: last-level-cache replacement with a
// hashed perceptron reuse predictor, sampler sets and tree pseudo-lru.
// Depends on prr_pkg, prr_ctrl and prr_datapath.
`timescale 1ns / 1ps

//  channel   direction  handshake              payload
//  req       in         req_valid / req_stall  opcode set_index way pc address line_tag is_hit
//  rsp       out        rsp_valid / rsp_stall  victim_way bypass
//  cfg       in         cfg_write              cfg_index cfg_data
//
//  one word at a time through the sequencer: decode steps (accept plus
//  set modulo and sampler number by reciprocal multiply), then a query runs
//  on to its result, on a sampler set with the sampler entry read ahead of
//  the weight read; an update ends early when the way is out of range
//  after reset a clearing pass over max(NUM_SETS, SAMPLER_SETS*WAYS, 256) addresses
//  (4096 by default) sweeps every memory; requests are stalled meanwhile
//  a result waits in the output register under rsp_stall while the next
//  request is already taken; only the next result step waits for it

module perceptron_reuse_replacement_top #(
  parameter int NUM_SETS     = prr_pkg::NUM_SETS_DEF,
  parameter int WAYS         = prr_pkg::WAYS_DEF,
  parameter int SAMPLER_SETS = prr_pkg::SAMPLER_SETS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // request channel
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic                           opcode,
  input  logic [11:0]                    set_index,
  input  logic [3:0]                     way,
  input  logic [10:0]                    pc,
  input  logic [63:0]                    address,
  input  logic [14:0]                    line_tag,
  input  logic                           is_hit,
  // result channel
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic [3:0]                     victim_way,
  output logic                           bypass,
  // configuration
  input  logic                           cfg_write,
  input  logic [prr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import prr_pkg::*;

  // commands down, status up
  prr_cmd_t    cmd;
  prr_status_t status;

  prr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // memories, weight tables, decode arithmetic and the result register
  prr_datapath #(
    .NUM_SETS     (NUM_SETS),
    .WAYS         (WAYS),
    .SAMPLER_SETS (SAMPLER_SETS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .opcode     (opcode),
    .set_index  (set_index),
    .way        (way),
    .pc         (pc),
    .address    (address),
    .line_tag   (line_tag),
    .is_hit     (is_hit),
    .victim_way (victim_way),
    .bypass     (bypass)
  );

endmodule

/* sim/perceptron_reuse_replacement_top_test.sv */
// perceptron_reuse_replacement_top_test: self-checking bench for the
// perceptron reuse replacement block; depends on prr_pkg and the top level.
// Predicts victim words in step with accepted requests and checks each one.
`timescale 1ns / 1ps

module perceptron_reuse_replacement_top_test;
  import prr_pkg::*;

  localparam int NSETS     = 4096;
  localparam int NWAYS     = 16;
  localparam int SAMP_GAP  = 64;     // one sampler set every 64 sets
  localparam int NSAMP     = 64;
  localparam int IDLE_LIMIT = 20000; // covers the clearing pass and long holds
  localparam int SETTLE    = 40;     // longest internal latency, with margin
  localparam logic OP_QUERY  = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic opcode = 1'b0;
  logic [11:0] set_index = '0;
  logic [3:0] way = '0;
  logic [10:0] pc = '0;
  logic [63:0] address = '0;
  logic [14:0] line_tag = '0;
  logic is_hit = 1'b0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic [3:0] victim_way;
  logic bypass;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  perceptron_reuse_replacement_top u_top (.*);

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // predictor state, a private copy of everything the block remembers
  // ---------------------------------------------------------------------
  typedef struct {
    logic [3:0] vway;
    logic       byp;
  } victim_t;

  victim_t     victim_q[$];
  int          errors = 0;

  logic [7:0]  thr_train;
  int          thr_bypass, thr_reuse;
  logic [5:0]  tag_sh;

  bit          reuse_mem[NSETS*NWAYS];
  logic [14:0] plru_mem[NSETS];
  logic [7:0]  samp_feat[NSAMP*NWAYS][FEATURES];
  int          samp_sum[NSAMP*NWAYS];
  int          samp_lru[NSAMP*NWAYS];
  int          weights[FEATURES][TABLE_ENTRIES];
  logic [10:0] pc_hist[4];

  // stimulus shaping knobs
  int  hold_left = 0;   // receiver hold-off, counted down by the stall process
  bit  quiet = 0;       // no idling on either side while set

  function automatic void model_reset();
    thr_train  = TRAIN_THR_RST;
    thr_bypass = BYPASS_THR_RST;
    thr_reuse  = REUSE_THR_RST;
    tag_sh     = TAG_SHIFT_RST;
    foreach (reuse_mem[i]) reuse_mem[i] = 1'b0;
    foreach (plru_mem[i]) plru_mem[i] = '0;
    for (int e = 0; e < NSAMP*NWAYS; e++) begin
      for (int f = 0; f < FEATURES; f++) samp_feat[e][f] = '0;
      samp_sum[e] = 0;
      samp_lru[e] = e % NWAYS;
    end
    for (int f = 0; f < FEATURES; f++)
      for (int t = 0; t < TABLE_ENTRIES; t++) weights[f][t] = 0;
    for (int h = 0; h < 4; h++) pc_hist[h] = '0;
  endfunction

  function automatic int feature_sum(input logic [7:0] ix[FEATURES]);
    int s;
    s = 0;
    for (int f = 0; f < FEATURES; f++) s += weights[f][ix[f]];
    return s;
  endfunction

  // nudge one sampler entry's six weights, saturating at the rails
  function automatic void nudge_weights(input int e, input bit up);
    int w;
    for (int f = 0; f < FEATURES; f++) begin
      w = weights[f][samp_feat[e][f]];
      if (up && w < W_MAX) w++;
      else if (!up && w > W_MIN) w--;
      weights[f][samp_feat[e][f]] = w;
    end
  endfunction

  // fill hashes, used both for sampler fills and for the reuse bit
  function automatic void fill_hash(input logic [10:0] p11, input logic [14:0] tg,
                                    output logic [7:0] ix[FEATURES]);
    logic [7:0] p;
    p = p11[7:0];
    ix[0] = 8'(pc_hist[0] >> 2) ^ p;
    ix[1] = 8'(pc_hist[1] >> 1) ^ p;
    ix[2] = 8'(pc_hist[2] >> 2) ^ p;
    ix[3] = 8'(pc_hist[3] >> 3) ^ p;
    ix[4] = 8'(tg >> 4) ^ p;
    ix[5] = 8'(tg >> 7) ^ p;
  endfunction

  function automatic void push_hist(input logic [10:0] p);
    pc_hist[3] = pc_hist[2];
    pc_hist[2] = pc_hist[1];
    pc_hist[1] = pc_hist[0];
    pc_hist[0] = p;
  endfunction

  // one accepted request; returns 1 when a victim word is due
  function automatic bit replacement_predict(input logic op, input logic [11:0] st,
      input logic [3:0] wy, input logic [10:0] p11, input logic [63:0] addr,
      input logic [14:0] tg, input logic hit, output victim_t res);
    logic [7:0]  ix[FEATURES];
    logic [7:0]  p;
    logic [31:0] qtag;
    int          sidx, base, e, cur, node, vw, theta;
    bit          samp, found;
    samp  = (st % SAMP_GAP) == 0;
    sidx  = st / SAMP_GAP;
    base  = sidx * NWAYS;
    theta = thr_train;
    res.vway = '0;
    res.byp  = 1'b0;
    if (op == OP_QUERY) begin
      qtag = 32'(addr >> tag_sh);
      if (samp) begin
        vw = 0;
        for (int w = NWAYS-1; w >= 0; w--) if (samp_lru[base+w] == NWAYS-1) vw = w;
        if (samp_sum[base+vw] < theta || reuse_mem[st*NWAYS+vw]) nudge_weights(base+vw, 1);
        res.vway = 4'(vw);
        return 1;
      end
      p = p11[7:0];
      ix[0] = 8'(p11 >> 2) ^ p;
      ix[1] = 8'(pc_hist[0] >> 1) ^ p;
      ix[2] = 8'(pc_hist[1] >> 2) ^ p;
      ix[3] = 8'(pc_hist[2] >> 3) ^ p;
      ix[4] = 8'(qtag >> 4) ^ p;
      ix[5] = 8'(qtag >> 7) ^ p;
      if (feature_sum(ix) > thr_bypass) begin
        push_hist(p11);
        res.byp = 1'b1;
        return 1;
      end
      found = 0;
      for (int w = 0; w < NWAYS; w++)
        if (!found && !reuse_mem[st*NWAYS+w]) begin
          found = 1;
          res.vway = 4'(w);
        end
      if (!found) begin
        // walk the pseudo-lru tree from the root
        node = 0;
        while (node < NWAYS-1) node = 2*node + 1 + plru_mem[st][node];
        res.vway = 4'(node - (NWAYS-1));
      end
      return 1;
    end
    push_hist(p11);
    if (samp) begin
      e = base + wy;
      if (hit) begin
        if (samp_sum[e] > -theta) nudge_weights(e, 0);
      end else begin
        fill_hash(p11, tg, ix);
        for (int f = 0; f < FEATURES; f++) samp_feat[e][f] = ix[f];
        samp_sum[e] = feature_sum(ix);
      end
      cur = samp_lru[e];
      for (int w = 0; w < NWAYS; w++) if (samp_lru[base+w] < cur) samp_lru[base+w]++;
      samp_lru[e] = 0;
    end else begin
      node = NWAYS - 1 + wy;
      while (node > 0) begin
        if (node % 2 == 0) begin
          node = (node - 2) / 2;
          plru_mem[st][node] = 1'b0;
        end else begin
          node = (node - 1) / 2;
          plru_mem[st][node] = 1'b1;
        end
      end
    end
    fill_hash(pc_hist[0], tg, ix);
    reuse_mem[st*NWAYS+wy] = feature_sum(ix) < thr_reuse;
    return 0;
  endfunction

  // ---------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_word(input logic op, input logic [11:0] st, input logic [3:0] wy,
      input logic [10:0] p11, input logic [63:0] addr, input logic [14:0] tg,
      input logic hit, output victim_t res, output bit due);
    int g;
    @(negedge clk);
    req_valid = 1'b1;
    opcode = op;
    set_index = st;
    way = wy;
    pc = p11;
    address = addr;
    line_tag = tg;
    is_hit = hit;
    do @(posedge clk); while (req_stall);
    due = replacement_predict(op, st, wy, p11, addr, tg, hit, res);
    if (due) victim_q.push_back(res);
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      req_valid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  // wait for every victim word, then for work on trailing updates to finish
  task automatic drain();
    @(negedge clk);
    req_valid = 1'b0;
    wait (victim_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [8:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      CFG_TRAIN_THR:  thr_train = val[7:0];
      CFG_BYPASS_THR: thr_bypass = $signed(val);
      CFG_REUSE_THR:  thr_reuse = $signed(val);
      CFG_TAG_SHIFT:  tag_sh = val[5:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [8:0] tr, input logic [8:0] byp,
                         input logic [8:0] reu, input logic [8:0] sh);
    drain();
    write_cfg(CFG_TRAIN_THR, tr);
    write_cfg(CFG_BYPASS_THR, byp);
    write_cfg(CFG_REUSE_THR, reu);
    write_cfg(CFG_TAG_SHIFT, sh);
  endtask

  // mostly a small pool of sets, with sampler sets well represented
  function automatic logic [11:0] pick_set();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 12'($urandom);
    if (r < 6) return 12'($urandom_range(0, 7) * SAMP_GAP);
    return 12'($urandom_range(0, 7) * SAMP_GAP + $urandom_range(1, 3));
  endfunction

  function automatic logic [10:0] pick_pc();
    if ($urandom_range(0, 1)) return 11'($urandom_range(0, 15) * 37);
    return 11'($urandom);
  endfunction

  // miss, fill of the predicted way unless bypassed, then a few hits in the same set;
  // otherwise a lone random word for noise
  task automatic random_burst();
    victim_t     r;
    bit          due;
    logic [11:0] st;
    logic [14:0] tg;
    st = pick_set();
    tg = 15'($urandom_range(0, 31) * 613);
    if ($urandom_range(0, 9) < 3) begin
      send_word(1'($urandom), 12'($urandom), 4'($urandom), 11'($urandom),
                {$urandom, $urandom}, 15'($urandom), 1'($urandom), r, due);
      return;
    end
    send_word(OP_QUERY, st, 4'($urandom), pick_pc(), {$urandom, $urandom},
              15'($urandom), 1'($urandom), r, due);
    if (!r.byp)
      send_word(OP_UPDATE, st, r.vway, pick_pc(), {$urandom, $urandom}, tg, 1'b0, r, due);
    repeat ($urandom_range(0, 3))
      send_word(OP_UPDATE, st, 4'($urandom), pick_pc(), {$urandom, $urandom},
                tg, 1'b1, r, due);
  endtask

  // ---------------------------------------------------------------------
  // test tasks
  // ---------------------------------------------------------------------
  task automatic test_directed();
    victim_t r;
    bit      due;
    quiet = 1;
    // reset defaults: sampler set and ordinary set, query and fill
    send_word(OP_QUERY, 12'd0, 4'd0, 11'd0, 64'd0, 15'd0, 1'b0, r, due);
    send_word(OP_UPDATE, 12'd0, 4'd0, 11'd0, 64'd0, 15'd0, 1'b0, r, due);
    send_word(OP_UPDATE, 12'd0, 4'd0, 11'h7ff, 64'd0, 15'h7fff, 1'b1, r, due);
    send_word(OP_QUERY, 12'd1, 4'd0, 11'h7ff, '1, 15'h7fff, 1'b1, r, due);
    send_word(OP_UPDATE, 12'd4095, 4'd15, 11'h7ff, '1, 15'h7fff, 1'b0, r, due);
    send_word(OP_QUERY, 12'd4095, 4'd15, 11'h7ff, '1, 15'h7fff, 1'b0, r, due);
    send_word(OP_UPDATE, 12'd4032, 4'd15, 11'h555, 64'h5555_5555_5555_5555, 15'h2aaa,
              1'b0, r, due);
    send_word(OP_QUERY, 12'd4032, 4'd3, 11'h2aa, 64'haaaa_aaaa_aaaa_aaaa, 15'h5555,
              1'b1, r, due);
    // extreme settings: tag shift zero and at the address top
    set_all(9'd0, 9'h100, 9'h100, 9'd0);
    send_word(OP_QUERY, 12'd64, 4'd0, 11'd3, '1, 15'd0, 1'b0, r, due);
    send_word(OP_UPDATE, 12'd64, 4'd5, 11'd3, '1, 15'h7fff, 1'b1, r, due);
    send_word(OP_QUERY, 12'd65, 4'd0, 11'd9, '1, 15'd0, 1'b0, r, due);
    set_all(9'd255, 9'h0ff, 9'h0ff, 9'd63);
    send_word(OP_QUERY, 12'd65, 4'd0, 11'd9, '1, 15'd0, 1'b0, r, due);
    send_word(OP_UPDATE, 12'd65, 4'd2, 11'd9, 64'd0, 15'h7fff, 1'b0, r, due);
    send_word(OP_QUERY, 12'd128, 4'd0, 11'd100, '1, 15'd0, 1'b0, r, due);
    // bypass threshold below any sum: every query on an ordinary set bypasses
    set_all(9'd255, 9'h100, 9'h0ff, 9'd48);
    send_word(OP_QUERY, 12'd2, 4'd0, 11'd1, 64'h8000_0000_0000_0000, 15'd0, 1'b0, r, due);
    send_word(OP_QUERY, 12'd3, 4'd0, 11'd2, '1, 15'd0, 1'b0, r, due);
    quiet = 0;
  endtask

  task automatic test_random_phases();
    logic [8:0] cfgs[5][4];
    cfgs = '{'{9'd68, 9'd3, 9'd124, 9'd18},  '{9'd0, 9'h100, 9'h100, 9'd0},
             '{9'd255, 9'd255, 9'd255, 9'd63}, '{9'd10, 9'h1fb, 9'd0, 9'd48},
             '{9'($urandom), 9'($urandom), 9'($urandom), 9'($urandom_range(0, 63))}};
    foreach (cfgs[i]) begin
      set_all(cfgs[i][0], cfgs[i][1], cfgs[i][2], cfgs[i][3]);
      quiet = (i == 2);
      repeat (100) random_burst();
    end
    quiet = 0;
  endtask

  // receiver holds off while the sender keeps offering, then the sender
  // waits for everything outstanding before going on
  task automatic test_backpressure();
    victim_t r;
    bit      due;
    drain();
    hold_left = 400;
    quiet = 1;
    repeat (40)
      send_word(OP_QUERY, pick_set(), 4'd0, pick_pc(), {$urandom, $urandom}, 15'd0,
                1'b0, r, due);
    quiet = 0;
    drain();
    repeat (30) random_burst();
  endtask

  // ---------------------------------------------------------------------
  // receiver stall, result checking and watchdog
  // ---------------------------------------------------------------------
  int stall_left = 0;
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_stall = 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      rsp_stall = 1'b1;
    end else begin
      rsp_stall = 1'b0;
      if (!quiet && $urandom_range(0, 3) == 0)
        stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 3);
    end
  end

  always @(posedge clk) begin
    victim_t x;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (victim_q.size() == 0) begin
        errors++;
        $display("%0t unexpected victim word: victim_way %0d bypass %0b",
                 $time, victim_way, bypass);
      end else begin
        x = victim_q.pop_front();
        if (victim_way !== x.vway) begin
          errors++;
          $display("%0t victim_way expected %0d actual %0d", $time, x.vway, victim_way);
        end
        if (bypass !== x.byp) begin
          errors++;
          $display("%0t bypass expected %0b actual %0b", $time, x.byp, bypass);
        end
      end
    end
  end

  int idle_count = 0;
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= IDLE_LIMIT) begin
      $display("FAIL perceptron_reuse_replacement_top");
      $finish;
    end
  end

  initial begin
    model_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random_phases();
    test_backpressure();
    drain();
    if (victim_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("PASS perceptron_reuse_replacement_top");
    end else begin
      $display("FAIL perceptron_reuse_replacement_top");
    end
    $finish;
  end

endmodule
